### rtl/kot_pkg.sv
// Shared types and constants for the keyed offset table.
// Used by kot_store, kot_ctrl and keyed_offset_table; depends on nothing.
package kot_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Request codes
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_DONE     = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_DISABLED = 2'd2;

  // One table slot
  typedef struct packed {
    logic [31:0] process_id;
    logic [31:0] port_handle;
    logic [31:0] offset;
  } entry_t;

  // Store read port request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  // Store write port request
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  // One result transfer
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [31:0] offset;
    logic [1:0]  status;
  } result_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE       = 4'b0001,
    S_SCAN       = 4'b0010,
    S_SHIFT_UP   = 4'b0100,
    S_SHIFT_DOWN = 4'b1000
  } state_t;

endpackage

### rtl/kot_store.sv
// Slot store of the keyed offset table: one write port, one registered read port.
// Depends on kot_pkg for the entry layout and depth.
module kot_store (
  input  logic             clk,
  input  kot_pkg::rd_req_t rd,
  input  kot_pkg::wr_req_t wr,
  output kot_pkg::entry_t  rd_data
);

  kot_pkg::entry_t mem [kot_pkg::TABLE_DEPTH];

  // Write one slot
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read one slot, data in the next cycle
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/kot_ctrl.sv
// Sequencer of the keyed offset table: scans slots through the key comparator, then
// on insert or remove moves slots one a cycle to open or close a gap. Depends on kot_pkg.
module kot_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [1:0]              req_type,
  input  logic [31:0]             process_id,
  input  logic [31:0]             port_handle,
  input  logic [31:0]             virtual_offset,
  input  logic                    table_enable,
  input  kot_pkg::entry_t         rd_data,
  output logic                    busy,
  output kot_pkg::rd_req_t        rd,
  output kot_pkg::wr_req_t        wr,
  output kot_pkg::result_t        res
);

  kot_pkg::state_t state, state_next;

  logic [kot_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic [kot_pkg::CNT_W-1:0]  idx, idx_next;
  logic                       rd_pend, rd_pend_next;
  logic [kot_pkg::ADDR_W-1:0] rd_idx, rd_idx_next;
  logic                       hit, hit_next;
  logic [kot_pkg::ADDR_W-1:0] hit_idx, hit_idx_next;
  logic [31:0]                hit_off, hit_off_next;

  logic [1:0]  req;
  logic [31:0] key_pid;
  logic [31:0] key_handle;
  logic [31:0] key_voff;

  logic                       match;
  logic [kot_pkg::CNT_W-1:0]  idx_dec;
  logic [kot_pkg::CNT_W-1:0]  idx_inc;
  logic                       accept;

  assign busy    = (state != kot_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign idx_dec = idx - kot_pkg::CNT_W'(1);
  assign idx_inc = idx + kot_pkg::CNT_W'(1);

  // Shared key comparator on the slot just read
  assign match = rd_pend && (rd_data.process_id == key_pid) &&
                 (rd_data.port_handle == key_handle);

  // Sequencer
  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    idx_next     = idx;
    rd_pend_next = 1'b0;
    rd_idx_next  = rd_idx;
    hit_next     = hit;
    hit_idx_next = hit_idx;
    hit_off_next = hit_off;
    rd           = '0;
    wr           = '0;
    res          = '0;

    case (state)
      kot_pkg::S_IDLE: begin
        if (start) begin
          if (!table_enable) begin
            res.valid  = 1'b1;
            res.status = kot_pkg::STAT_DISABLED;
          end else if (req_type == kot_pkg::REQ_LOOKUP ||
                       req_type == kot_pkg::REQ_INSERT ||
                       req_type == kot_pkg::REQ_REMOVE) begin
            state_next = kot_pkg::S_SCAN;
            idx_next   = '0;
            hit_next   = 1'b0;
          end else begin
            // reserved request: answer at once, table untouched
            res.valid  = 1'b1;
            res.status = kot_pkg::STAT_DONE;
          end
        end
      end

      kot_pkg::S_SCAN: begin
        // record the newest match
        if (match && !hit) begin
          hit_next     = 1'b1;
          hit_idx_next = rd_idx;
          hit_off_next = rd_data.offset;
        end
        if (!hit && !match && idx < cnt) begin
          // advance to the next slot
          rd.en        = 1'b1;
          rd.addr      = idx[kot_pkg::ADDR_W-1:0];
          rd_pend_next = 1'b1;
          rd_idx_next  = idx[kot_pkg::ADDR_W-1:0];
          idx_next     = idx_inc;
        end else if (!rd_pend) begin
          case (req)
            kot_pkg::REQ_LOOKUP: begin
              res.valid  = 1'b1;
              res.found  = hit;
              res.offset = hit ? hit_off : 32'd0;
              res.status = kot_pkg::STAT_DONE;
              state_next = kot_pkg::S_IDLE;
            end
            kot_pkg::REQ_INSERT: begin
              if (cnt == kot_pkg::CNT_W'(kot_pkg::TABLE_DEPTH)) begin
                // drop the insert, table full
                res.valid  = 1'b1;
                res.found  = hit;
                res.status = kot_pkg::STAT_FULL;
                state_next = kot_pkg::S_IDLE;
              end else begin
                state_next = kot_pkg::S_SHIFT_UP;
                idx_next   = cnt;
              end
            end
            default: begin
              if (hit) begin
                state_next = kot_pkg::S_SHIFT_DOWN;
                idx_next   = kot_pkg::CNT_W'(hit_idx) + kot_pkg::CNT_W'(1);
              end else begin
                res.valid  = 1'b1;
                res.status = kot_pkg::STAT_DONE;
                state_next = kot_pkg::S_IDLE;
              end
            end
          endcase
        end
      end

      kot_pkg::S_SHIFT_UP: begin
        // write back the slot read last cycle one place further down
        if (rd_pend) begin
          wr.en   = 1'b1;
          wr.addr = rd_idx + kot_pkg::ADDR_W'(1);
          wr.data = rd_data;
        end
        if (idx != '0) begin
          rd.en        = 1'b1;
          rd.addr      = idx_dec[kot_pkg::ADDR_W-1:0];
          rd_pend_next = 1'b1;
          rd_idx_next  = idx_dec[kot_pkg::ADDR_W-1:0];
          idx_next     = idx_dec;
        end else if (!rd_pend) begin
          // place the new entry at the front
          wr.en              = 1'b1;
          wr.addr            = '0;
          wr.data.process_id = key_pid;
          wr.data.port_handle = key_handle;
          wr.data.offset     = key_voff;
          cnt_next           = cnt + kot_pkg::CNT_W'(1);
          res.valid          = 1'b1;
          res.found          = hit;
          res.status         = kot_pkg::STAT_DONE;
          state_next         = kot_pkg::S_IDLE;
        end
      end

      kot_pkg::S_SHIFT_DOWN: begin
        // close the gap: move each later slot one place up
        if (rd_pend) begin
          wr.en   = 1'b1;
          wr.addr = rd_idx - kot_pkg::ADDR_W'(1);
          wr.data = rd_data;
        end
        if (idx < cnt) begin
          rd.en        = 1'b1;
          rd.addr      = idx[kot_pkg::ADDR_W-1:0];
          rd_pend_next = 1'b1;
          rd_idx_next  = idx[kot_pkg::ADDR_W-1:0];
          idx_next     = idx_inc;
        end else if (!rd_pend) begin
          cnt_next   = cnt - kot_pkg::CNT_W'(1);
          res.valid  = 1'b1;
          res.found  = 1'b1;
          res.status = kot_pkg::STAT_DONE;
          state_next = kot_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = kot_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kot_pkg::S_IDLE;
      cnt     <= '0;
      idx     <= '0;
      rd_pend <= 1'b0;
      hit     <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      idx     <= idx_next;
      rd_pend <= rd_pend_next;
      hit     <= hit_next;
    end
  end

  // Payload registers: hold the request for the whole walk
  always_ff @(posedge clk) begin
    rd_idx  <= rd_idx_next;
    hit_idx <= hit_idx_next;
    hit_off <= hit_off_next;
    if (accept) begin
      req        <= req_type;
      key_pid    <= process_id;
      key_handle <= port_handle;
      key_voff   <= virtual_offset;
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= kot_pkg::CNT_W'(kot_pkg::TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> state != kot_pkg::S_IDLE)
    else $error("store written while idle");

  a_res_to_idle: assert property (@(posedge clk) disable iff (rst)
    res.valid |=> state == kot_pkg::S_IDLE)
    else $error("sequencer not idle after a result");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status == kot_pkg::STAT_FULL) |->
      cnt == kot_pkg::CNT_W'(kot_pkg::TABLE_DEPTH))
    else $error("full status with free slots");

  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (accept && table_enable &&
     (req_type == kot_pkg::REQ_LOOKUP || req_type == kot_pkg::REQ_INSERT ||
      req_type == kot_pkg::REQ_REMOVE)) |=> state == kot_pkg::S_SCAN)
    else $error("accepted request did not start a scan");

endmodule

### rtl/keyed_offset_table.sv
// Top level of the keyed offset table: enable register, result registers,
// slot store and sequencer. Depends on kot_pkg, kot_store and kot_ctrl.
//
// A request is taken when start is high and busy is low; its single result appears
// on found, offset_out and status for one cycle with done high, and must be taken
// then, as the receiver cannot stall. With the table disabled or a reserved request
// code busy stays low and the result follows in the next cycle. Otherwise the block
// walks the slots through one key comparator and one memory port, one slot per
// cycle, and busy is high for the scan, up to the newest match or over all valid
// slots; then, for an insert into a table not full, while every entry moves down
// and the front slot is written, or, for a remove that matched, while the later
// slots move up to close the gap. done rises in the same cycle as busy falls, and
// the longest request is an insert into a table one short of full. Reset empties
// the table at once through its fill count.
module keyed_offset_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        start,
  input  logic [1:0]  req_type,
  input  logic [31:0] process_id,
  input  logic [31:0] port_handle,
  input  logic [31:0] virtual_offset,
  output logic        busy,
  output logic        done,
  output logic        found,
  output logic [31:0] offset_out,
  output logic [1:0]  status
);

  logic             table_enable;
  kot_pkg::rd_req_t rd;
  kot_pkg::wr_req_t wr;
  kot_pkg::entry_t  rd_data;
  kot_pkg::result_t res;

  // Enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_enable <= 1'b0;
    end else if (cfg_wen) begin
      table_enable <= cfg_wdata;
    end
  end

  kot_store u_store (
    .clk     (clk),
    .rd      (rd),
    .wr      (wr),
    .rd_data (rd_data)
  );

  kot_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .req_type       (req_type),
    .process_id     (process_id),
    .port_handle    (port_handle),
    .virtual_offset (virtual_offset),
    .table_enable   (table_enable),
    .rd_data        (rd_data),
    .busy           (busy),
    .rd             (rd),
    .wr             (wr),
    .res            (res)
  );

  // Register the result transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      found      <= res.found;
      offset_out <= res.offset;
      status     <= res.status;
    end
  end

endmodule
